// File: rtl/pwps_pkg.sv
package pwps_pkg;

    // number of palettes the index cycles through
    localparam int unsigned PALETTE_COUNT = 4;
    localparam int unsigned PAL_W = (PALETTE_COUNT > 2) ? $clog2(PALETTE_COUNT) : 1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // restoring divider: 24-bit dividend, 16-bit divisor
    localparam int unsigned DIV_STEPS = 24;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [15:0] MIN_PULSE_RST    = 16'd1;
    localparam logic [15:0] MAX_PULSE_RST    = 16'd4080;
    localparam logic [7:0]  JUMP_THRESH_RST  = 8'd10;
    localparam logic [15:0] SETTLE_MS_RST    = 16'd100;
    localparam logic [15:0] CLEAR_PERIOD_RST = 16'd1000;

    localparam logic [7:0] LEVEL_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PULSE    = 3'd0,
        CFG_MAX_PULSE    = 3'd1,
        CFG_JUMP_THRESH  = 3'd2,
        CFG_SETTLE_MS    = 3'd3,
        CFG_CLEAR_PERIOD = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        OP_PIN_EDGE   = 1'b0,
        OP_FRAME_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic        operation;
        logic        pin_level;
        logic [31:0] time_us;
        logic [31:0] time_ms;
    } in_word_t;

    typedef struct packed {
        logic       report_valid;
        logic [7:0] reported_value;
        logic [1:0] palette_index;
        logic [7:0] mapped_level;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETTLE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic edge_load;
        logic tick_load;
        logic div_step;
        logic settle;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

// File: rtl/pwps_ctrl.sv
module pwps_ctrl
    import pwps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    operation,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == OP_FRAME_TICK)
                    begin
                        cmd.tick_load = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.edge_load = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_busy)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                // hold here until the output register can take the word
                if (status.out_free)
                begin
                    cmd.settle = 1'b1;
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pwps_datapath.sv
module pwps_datapath
    import pwps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_word,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    logic [15:0] min_pulse_reg;
    logic [15:0] max_pulse_reg;
    logic [7:0]  jump_thresh_reg;
    logic [15:0] settle_ms_reg;
    logic [15:0] clear_period_reg;

    logic [31:0]      pulse_start_reg;
    logic [31:0]      pulse_width_reg;
    logic [7:0]       last_level_reg;
    logic [31:0]      settle_start_reg;
    logic [31:0]      clear_start_reg;
    logic [7:0]       last_report_reg;
    logic             report_seen_reg;
    logic [PAL_W-1:0] palette_sel_reg;

    logic [31:0]          tms_reg;
    logic [7:0]           level_reg;
    logic                 use_div_reg;
    logic [15:0]          rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 out_valid_reg;
    out_word_t            out_word_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg    <= MIN_PULSE_RST;
            max_pulse_reg    <= MAX_PULSE_RST;
            jump_thresh_reg  <= JUMP_THRESH_RST;
            settle_ms_reg    <= SETTLE_MS_RST;
            clear_period_reg <= CLEAR_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_PULSE:    min_pulse_reg    <= cfg_data;
                CFG_MAX_PULSE:    max_pulse_reg    <= cfg_data;
                CFG_JUMP_THRESH:  jump_thresh_reg  <= cfg_data[7:0];
                CFG_SETTLE_MS:    settle_ms_reg    <= cfg_data;
                CFG_CLEAR_PERIOD: clear_period_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // pin edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_start_reg <= '0;
            pulse_width_reg <= '0;
        end
        else if (cmd.edge_load)
        begin
            if (in_word.pin_level)
            begin
                pulse_start_reg <= in_word.time_us;
            end
            else
            begin
                pulse_width_reg <= in_word.time_us - pulse_start_reg;
            end
        end
    end

    // tick setup: clamp cases or load the divider
    logic                 range_bad;
    logic                 width_low;
    logic                 width_high;
    logic [15:0]          width_off;
    logic [15:0]          divisor;
    logic [DIV_STEPS-1:0] dividend;
    logic [7:0]           cur_level;
    logic [7:0]           level_diff;

    assign range_bad  = (max_pulse_reg <= min_pulse_reg);
    assign width_low  = (pulse_width_reg <= {16'd0, min_pulse_reg});
    assign width_high = (pulse_width_reg >= {16'd0, max_pulse_reg});
    // width lies strictly between min and max when the divider runs
    assign width_off  = pulse_width_reg[15:0] - min_pulse_reg;
    assign divisor    = max_pulse_reg - min_pulse_reg;
    // offset times 255
    assign dividend   = {width_off, 8'd0} - {8'd0, width_off};

    logic [16:0]          rem_shift;
    logic [16:0]          rem_trial;
    logic                 trial_ok;
    logic [15:0]          rem_next;
    logic [DIV_STEPS-1:0] quo_next;

    assign rem_shift = {rem_reg, quo_reg[DIV_STEPS-1]};
    assign rem_trial = rem_shift - {1'b0, divisor};
    assign trial_ok  = !rem_trial[16];
    assign rem_next  = trial_ok ? rem_trial[15:0] : rem_shift[15:0];
    assign quo_next  = {quo_reg[DIV_STEPS-2:0], trial_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.tick_load)
        begin
            if (range_bad || width_low || width_high)
            begin
                div_cnt_reg <= '0;
            end
            else
            begin
                div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
            end
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_load)
        begin
            tms_reg     <= in_word.time_ms;
            rem_reg     <= '0;
            quo_reg     <= dividend;
            use_div_reg <= !(range_bad || width_low || width_high);
            level_reg   <= width_low ? 8'd0 : LEVEL_MAX;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        else if (cmd.settle)
        begin
            level_reg <= cur_level;
        end
    end

    // settling timer
    assign cur_level  = use_div_reg ? quo_reg[7:0] : level_reg;
    assign level_diff = (cur_level > last_level_reg) ? cur_level - last_level_reg
                                                     : last_level_reg - cur_level;

    // report and periodic clear
    logic [31:0]      settle_elapsed;
    logic [31:0]      clear_elapsed;
    logic             settled;
    logic [7:0]       rev_level;
    logic             fire;
    logic [PAL_W-1:0] palette_next;
    logic [1:0]       palette_ext;

    assign settle_elapsed = tms_reg - settle_start_reg;
    assign clear_elapsed  = tms_reg - clear_start_reg;
    assign settled        = (settle_elapsed > {16'd0, settle_ms_reg});
    assign rev_level      = LEVEL_MAX - level_reg;
    assign fire           = settled && (!report_seen_reg || (rev_level != last_report_reg));

    always_comb
    begin
        palette_next = palette_sel_reg;
        if (fire && (rev_level == LEVEL_MAX))
        begin
            if (palette_sel_reg == PAL_W'(PALETTE_COUNT - 1))
            begin
                palette_next = '0;
            end
            else
            begin
                palette_next = palette_sel_reg + PAL_W'(1);
            end
        end
    end

    assign palette_ext = 2'(palette_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= '0;
            settle_start_reg <= '0;
            clear_start_reg  <= '0;
            last_report_reg  <= '0;
            report_seen_reg  <= 1'b0;
            palette_sel_reg  <= '0;
        end
        else if (cmd.settle)
        begin
            if (level_diff > jump_thresh_reg)
            begin
                settle_start_reg <= tms_reg;
            end
        end
        else if (cmd.report)
        begin
            palette_sel_reg <= palette_next;
            if (fire)
            begin
                last_report_reg <= rev_level;
                report_seen_reg <= 1'b1;
            end
            if (clear_elapsed >= {16'd0, clear_period_reg})
            begin
                clear_start_reg <= tms_reg;
                last_level_reg  <= '0;
            end
            else
            begin
                last_level_reg <= level_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            out_word_reg.report_valid   <= fire;
            out_word_reg.reported_value <= fire ? rev_level : last_report_reg;
            out_word_reg.palette_index  <= palette_ext;
            out_word_reg.mapped_level   <= level_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_word        = out_word_reg;
    assign status.div_busy = (div_cnt_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// File: rtl/pulse_width_palette_selector.sv
// pulse width palette selector
// input channel (in_valid/in_ready/in_word) takes two kinds of word: a pin
// edge records the pulse start on a rising edge and the pulse width on a
// falling edge; a frame tick maps the stored width onto a level 0..255 and
// runs the settling, report and palette logic
// a pin edge leaves the block idle and ready for the next word, and gives no output word
// a frame tick gives exactly one output word on out_valid/out_ready; the
// level goes through a restoring divider at one quotient bit per cycle
// (skipped when the width is clamped), then the settle and report states;
// the next word is accepted as soon as the output register loads
// configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; not enforced here
// reset returns the configuration registers to their defaults and clears the stored times,
// levels, report history and palette index
// a stalled receiver holds the word in the output register; a following
// tick runs up to its divider result and then waits for the register to empty
module pulse_width_palette_selector
    import pwps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    cmd_t    cmd;
    status_t status;

    pwps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_word.operation),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pwps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwps_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_word_t              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;

    // traffic shaping
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold = 1'b0;

    // mirror of the block's registers and state
    logic [15:0] cur_min_us = MIN_PULSE_RST;
    logic [15:0] cur_max_us = MAX_PULSE_RST;
    logic [7:0]  cur_jump = JUMP_THRESH_RST;
    logic [15:0] cur_settle_ms = SETTLE_MS_RST;
    logic [15:0] cur_clear_ms = CLEAR_PERIOD_RST;
    logic [31:0] rise_us = '0;
    logic [31:0] width_us = '0;
    logic [31:0] settle_origin = '0;
    logic [31:0] clear_origin = '0;
    logic [7:0]  level_memory = '0;
    logic [7:0]  report_memory = '0;
    bit          report_done = 1'b0;
    int unsigned palette = 0;

    out_word_t   tick_results[$];

    int unsigned err_cnt = 0;
    int unsigned words_sent = 0;
    int unsigned ticks_sent = 0;
    int unsigned reports_due = 0;
    int unsigned cfg_sets = 0;

    // stimulus time base
    logic [31:0] now_us = '0;
    logic [31:0] now_ms = '0;
    logic [31:0] pulse_len = 32'd2000;

    pulse_width_palette_selector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] level_of(input logic [31:0] w);
        logic [63:0] scaled;
        if (cur_max_us <= cur_min_us)
            return (w <= 32'(cur_min_us)) ? 8'd0 : LEVEL_MAX;
        if (w <= 32'(cur_min_us))
            return 8'd0;
        if (w >= 32'(cur_max_us))
            return LEVEL_MAX;
        scaled = (64'(w - 32'(cur_min_us)) * 64'(LEVEL_MAX)) / 64'(cur_max_us - cur_min_us);
        return scaled[7:0];
    endfunction

    function automatic out_word_t tick_result(input logic [31:0] tms);
        out_word_t  r;
        logic [7:0] lvl;
        logic [7:0] delta;
        logic [7:0] flipped;
        lvl = level_of(width_us);
        delta = (lvl > level_memory) ? lvl - level_memory : level_memory - lvl;
        if (delta > cur_jump)
            settle_origin = tms;
        r.report_valid = 1'b0;
        if ((tms - settle_origin) > 32'(cur_settle_ms))
        begin
            flipped = LEVEL_MAX - lvl;
            if (!report_done || flipped != report_memory)
            begin
                r.report_valid = 1'b1;
                if (flipped == LEVEL_MAX)
                    palette = (palette + 1) % PALETTE_COUNT;
                report_memory = flipped;
                report_done = 1'b1;
            end
        end
        // the remembered level drops to zero once per clear period
        if ((tms - clear_origin) >= 32'(cur_clear_ms))
        begin
            clear_origin = tms;
            level_memory = 8'd0;
        end
        else
        begin
            level_memory = lvl;
        end
        r.reported_value = report_memory;
        r.palette_index = palette[1:0];
        r.mapped_level = lvl;
        return r;
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            note_error($sformatf("%s expected %0d actual %0d", name, want, got));
    endtask

    always @(posedge clk)
    begin : check_output
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tick_results.size() == 0)
            begin
                note_error($sformatf("unexpected word %p", out_word));
            end
            else
            begin
                want = tick_results.pop_front();
                check_field("report_valid", want.report_valid, out_word.report_valid);
                check_field("reported_value", want.reported_value, out_word.reported_value);
                check_field("palette_index", want.palette_index, out_word.palette_index);
                check_field("mapped_level", want.mapped_level, out_word.mapped_level);
            end
        end
    end

    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic push_word(input in_word_t w);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (w.operation == OP_FRAME_TICK)
        begin
            ticks_sent++;
            tick_results.push_back(tick_result(w.time_ms));
            if (tick_results[$].report_valid)
                reports_due++;
        end
        else if (w.pin_level)
        begin
            rise_us = w.time_us;
        end
        else
        begin
            width_us = w.time_us - rise_us;
        end
    endtask

    task automatic send_edge(input logic pin, input logic [31:0] us);
        in_word_t w;
        w.operation = OP_PIN_EDGE;
        w.pin_level = pin;
        w.time_us = us;
        w.time_ms = $urandom();
        push_word(w);
    endtask

    task automatic send_tick(input logic [31:0] ms);
        in_word_t w;
        w.operation = OP_FRAME_TICK;
        w.pin_level = 1'($urandom_range(0, 1));
        w.time_us = $urandom();
        w.time_ms = ms;
        push_word(w);
    endtask

    // wait for every pending tick word, then let an edge still in flight finish
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tick_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] min_us, input logic [15:0] max_us,
                               input logic [7:0] jump, input logic [15:0] settle,
                               input logic [15:0] clr);
        write_reg(CFG_MIN_PULSE, min_us);
        write_reg(CFG_MAX_PULSE, max_us);
        write_reg(CFG_JUMP_THRESH, 16'(jump));
        write_reg(CFG_SETTLE_MS, settle);
        write_reg(CFG_CLEAR_PERIOD, clr);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_min_us = min_us;
        cur_max_us = max_us;
        cur_jump = jump;
        cur_settle_ms = settle;
        cur_clear_ms = clr;
        cfg_sets++;
    endtask

    function automatic logic [31:0] pick_width();
        logic [31:0] span;
        span = (cur_max_us > cur_min_us) ? 32'(cur_max_us - cur_min_us) : 32'd200;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, cur_min_us);
            2: return 32'(cur_max_us) + $urandom_range(0, 2000);
            default: return 32'(cur_min_us) + $urandom_range(0, span);
        endcase
    endfunction

    // mostly whole pulses followed by a run of frame ticks, some raw noise words
    task automatic run_traffic(input int unsigned n);
        in_word_t    w;
        int unsigned sent;
        int unsigned ticks;
        int unsigned pick;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                w.operation = 1'($urandom_range(0, 1));
                w.pin_level = 1'($urandom_range(0, 1));
                w.time_us = $urandom();
                w.time_ms = $urandom();
                push_word(w);
                sent++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick >= 65)
                    pulse_len = pick_width();
                else if (pick >= 50)
                    pulse_len = pulse_len + $urandom_range(0, 3);
                send_edge(1'b1, now_us);
                now_us = now_us + pulse_len;
                send_edge(1'b0, now_us);
                now_us = now_us + $urandom_range(1000, 20000);
                ticks = $urandom_range(1, 12);
                repeat (ticks)
                begin
                    if ($urandom_range(0, 99) < 4)
                        now_ms = now_ms + $urandom_range(1000, 70000);
                    else
                        now_ms = now_ms + $urandom_range(0, 16);
                    send_tick(now_ms);
                end
                sent += ticks + 2;
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_tick(32'd0);
        // full-scale pulse, then settle and first report
        send_edge(1'b1, 32'd100);
        send_edge(1'b0, 32'd4180);
        send_tick(32'd50);
        send_tick(32'd150);
        send_tick(32'd151);
        // minimum pulse, reports 255 and advances the palette
        send_edge(1'b1, 32'd5000);
        send_edge(1'b0, 32'd5001);
        send_tick(32'd160);
        send_tick(32'd261);
        // pulse across the microsecond wrap
        send_edge(1'b1, 32'hFFFF_FFF0);
        send_edge(1'b0, 32'h0000_0800);
        send_tick(32'd400);
        send_tick(32'd999);
        send_tick(32'd1000);
        // falling edge with no rising edge before it
        send_edge(1'b0, 32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFF0);
        send_tick(32'h0000_0070);
        send_edge(1'b1, 32'd0);
        send_edge(1'b0, 32'd4079);
        send_tick(32'h0000_0100);
        send_tick(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_full_speed();
        load_config(16'd200, 16'd3000, 8'd5, 16'd40, 16'd500);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_traffic(300);
        drain();
    endtask

    task automatic test_sender_gaps();
        load_config(16'd0, 16'd65535, 8'd0, 16'd0, 16'd1);
        send_idle_pct = 74;
        recv_stall_pct = 0;
        run_traffic(250);
        drain();
    endtask

    task automatic test_receiver_stalls();
        load_config(16'd500, 16'd500, 8'd255, 16'd65535, 16'd65535);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        run_traffic(250);
        drain();
    endtask

    task automatic test_both_idle();
        // maximum below minimum and a clear on every tick
        load_config(16'd65535, 16'd0, 8'd10, 16'd5, 16'd0);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        run_traffic(250);
        drain();
    endtask

    task automatic test_time_wrap();
        load_config(16'd100, 16'd65535, 8'd3, 16'd20, 16'd65535);
        now_us = 32'hFFF0_0000;
        now_ms = 32'hFFFF_F000;
        send_idle_pct = 0;
        recv_stall_pct = 12;
        run_traffic(200);
        drain();
    endtask

    task automatic test_backpressure();
        load_config(MIN_PULSE_RST, MAX_PULSE_RST, JUMP_THRESH_RST, SETTLE_MS_RST,
                    CLEAR_PERIOD_RST);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (400) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        run_traffic(60);
        // sender holds until every tick word is back
        drain();
        run_traffic(100);
        drain();
    endtask

    task automatic test_random_config();
        repeat (3)
        begin
            load_config(16'($urandom_range(0, 4000)), 16'($urandom_range(1, 8000)),
                        8'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                        16'($urandom_range(0, 3000)));
            send_idle_pct = $urandom_range(0, 40);
            recv_stall_pct = $urandom_range(0, 40);
            now_ms = $urandom();
            now_us = $urandom();
            run_traffic(70);
            drain();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_speed();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_time_wrap();
        test_backpressure();
        test_random_config();
        $display("run covered %0d words, %0d frame ticks, %0d reports, %0d register sets",
                 words_sent, ticks_sent, reports_due, cfg_sets);
        $display("traffic mixes: none, sender gaps, receiver stalls, both, long hold; %0d errors",
                 err_cnt);
        if (err_cnt == 0 && tick_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/pwps_pkg.sv
rtl/pwps_ctrl.sv
rtl/pwps_datapath.sv
rtl/pulse_width_palette_selector.sv
dv/tb.sv
